/* hw/rtl/ps2mc_pkg.sv */
package ps2mc_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int BYTE_W    = 8;
    localparam int OUT_W     = 12;
    localparam int SPEED_W   = 4;
    localparam int RES_W     = 13;
    localparam int PROD_W    = 14;
    localparam int BTN_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = RES_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SPEED_W-1:0] SPEED_RST  = 4'd3;
    localparam logic [RES_W-1:0]   WIDTH_RST  = 13'd1024;
    localparam logic [RES_W-1:0]   HEIGHT_RST = 13'd768;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam int ALIGN_BIT  = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [RES_W-1:0]   screen_width;
        logic [RES_W-1:0]   screen_height;
    } cfg_t;

    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic              x_sign;
        logic              y_sign;
        logic [BYTE_W-1:0] x_mag;
        logic [BYTE_W-1:0] y_mag;
    } packet_t;

    typedef struct packed {
        logic    push;
        packet_t pkt;
    } q_wr_t;

    typedef struct packed {
        logic    empty;
        logic    full;
        packet_t pkt;
    } q_rd_t;

    typedef enum logic [2:0] {
        ST_STATUS = 3'b001,
        ST_XMOVE  = 3'b010,
        ST_YMOVE  = 3'b100
    } rx_state_t;

endpackage

/* hw/rtl/ps2mc_front.sv */
module ps2mc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  ps2mc_pkg::q_rd_t       q_rd,
    output ps2mc_pkg::q_wr_t       q_wr
);
    import ps2mc_pkg::*;

    rx_state_t         state_reg;
    rx_state_t         state_next;
    logic [BYTE_W-1:0] status_reg;
    logic [BYTE_W-1:0] status_next;
    logic [BYTE_W-1:0] x_move_reg;
    logic [BYTE_W-1:0] x_move_next;
    logic              in_fire;

    assign in_ready = !q_rd.full;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        x_move_next = x_move_reg;
        q_wr.push   = 1'b0;
        q_wr.pkt.buttons = status_reg[BTN_W-1:0];
        q_wr.pkt.x_sign  = status_reg[X_SIGN_BIT];
        q_wr.pkt.y_sign  = status_reg[Y_SIGN_BIT];
        q_wr.pkt.x_mag   = x_move_reg;
        q_wr.pkt.y_mag   = data_byte;
        if (in_fire)
        begin
            unique case (state_reg)
                ST_STATUS:
                begin
                    // resync: a status byte always has bit 3 set
                    if (data_byte[ALIGN_BIT])
                    begin
                        status_next = data_byte;
                        state_next  = ST_XMOVE;
                    end
                end
                ST_XMOVE:
                begin
                    x_move_next = data_byte;
                    state_next  = ST_YMOVE;
                end
                ST_YMOVE:
                begin
                    state_next = ST_STATUS;
                    q_wr.push  = !(status_reg[X_OVF_BIT] || status_reg[Y_OVF_BIT]);
                end
                default:
                begin
                    state_next = ST_STATUS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_STATUS;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        x_move_reg <= x_move_next;
    end

endmodule

/* hw/rtl/ps2mc_queue.sv */
module ps2mc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ps2mc_pkg::q_wr_t   q_wr,
    input  logic               pop,
    output ps2mc_pkg::q_rd_t   q_rd
);
    import ps2mc_pkg::*;

    packet_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_rd.empty = (count_reg == '0);
    assign q_rd.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_rd.pkt   = mem[rd_ptr_reg];

    assign do_push = q_wr.push && !q_rd.full;
    assign do_pop  = pop && !q_rd.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wr.pkt;
        end
    end

endmodule

/* hw/rtl/ps2mc_back.sv */
module ps2mc_back #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ps2mc_pkg::cfg_t                cfg,
    input  ps2mc_pkg::q_rd_t               q_rd,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ps2mc_pkg::OUT_W-1:0]    cursor_x,
    output logic [ps2mc_pkg::OUT_W-1:0]    cursor_y,
    output logic                           left_button,
    output logic                           right_button,
    output logic                           middle_button
);
    import ps2mc_pkg::*;

    localparam int SUM_W = ((COORD_BITS > PROD_W) ? COORD_BITS : PROD_W) + 2;

    logic                  a_valid_reg;
    logic [PROD_W-1:0]     a_prod_x_reg;
    logic [PROD_W-1:0]     a_prod_y_reg;
    logic [SUM_W-1:0]      a_lim_x_reg;
    logic [SUM_W-1:0]      a_lim_y_reg;
    logic [BTN_W-1:0]      a_btn_reg;

    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      cursor_x_reg;
    logic [OUT_W-1:0]      cursor_y_reg;
    logic [BTN_W-1:0]      btn_reg;

    logic                  a_load;
    logic                  b_fire;
    logic [PROD_W-1:0]     dx_ext;
    logic [PROD_W-1:0]     dy_ext;
    logic [PROD_W-1:0]     spd_ext;
    logic [PROD_W-1:0]     prod_x;
    logic [PROD_W-1:0]     prod_y;
    logic [SUM_W-1:0]      top_val;
    logic [SUM_W-1:0]      res_x;
    logic [SUM_W-1:0]      res_y;
    logic [SUM_W-1:0]      lim_x;
    logic [SUM_W-1:0]      lim_y;
    logic [SUM_W-1:0]      nx;
    logic [SUM_W-1:0]      ny;
    logic [SUM_W-1:0]      cx;
    logic [SUM_W-1:0]      cy;

    assign b_fire = a_valid_reg && (!out_valid_reg || out_ready);
    assign a_load = !a_valid_reg || b_fire;
    assign pop    = a_load && !q_rd.empty;

    // stage a: scale deltas, resolve clamp limits
    assign dx_ext  = {{(PROD_W - BYTE_W){q_rd.pkt.x_sign}}, q_rd.pkt.x_mag};
    assign dy_ext  = {{(PROD_W - BYTE_W){q_rd.pkt.y_sign}}, q_rd.pkt.y_mag};
    assign spd_ext = {{(PROD_W - SPEED_W){1'b0}}, cfg.speed};
    assign prod_x  = dx_ext * spd_ext;
    assign prod_y  = dy_ext * spd_ext;

    assign top_val = {{(SUM_W - 1){1'b0}}, 1'b1} << COORD_BITS;
    assign res_x   = {{(SUM_W - RES_W){1'b0}}, cfg.screen_width};
    assign res_y   = {{(SUM_W - RES_W){1'b0}}, cfg.screen_height};

    always_comb
    begin
        if (res_x == '0)
        begin
            lim_x = '0;
        end
        else if (res_x > top_val)
        begin
            lim_x = top_val - 1'b1;
        end
        else
        begin
            lim_x = res_x - 1'b1;
        end
        if (res_y == '0)
        begin
            lim_y = '0;
        end
        else if (res_y > top_val)
        begin
            lim_y = top_val - 1'b1;
        end
        else
        begin
            lim_y = res_y - 1'b1;
        end
    end

    // stage b: move and clamp, y grows downward
    assign nx = {{(SUM_W - COORD_BITS){1'b0}}, pos_x_reg}
              + {{(SUM_W - PROD_W){a_prod_x_reg[PROD_W-1]}}, a_prod_x_reg};
    assign ny = {{(SUM_W - COORD_BITS){1'b0}}, pos_y_reg}
              - {{(SUM_W - PROD_W){a_prod_y_reg[PROD_W-1]}}, a_prod_y_reg};

    always_comb
    begin
        if (nx[SUM_W-1])
        begin
            cx = '0;
        end
        else if (nx > a_lim_x_reg)
        begin
            cx = a_lim_x_reg;
        end
        else
        begin
            cx = nx;
        end
        if (ny[SUM_W-1])
        begin
            cy = '0;
        end
        else if (ny > a_lim_y_reg)
        begin
            cy = a_lim_y_reg;
        end
        else
        begin
            cy = ny;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= !q_rd.empty;
            end
            if (b_fire)
            begin
                out_valid_reg <= 1'b1;
                pos_x_reg     <= cx[COORD_BITS-1:0];
                pos_y_reg     <= cy[COORD_BITS-1:0];
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_prod_x_reg <= prod_x;
            a_prod_y_reg <= prod_y;
            a_lim_x_reg  <= lim_x;
            a_lim_y_reg  <= lim_y;
            a_btn_reg    <= q_rd.pkt.buttons;
        end
        if (b_fire)
        begin
            cursor_x_reg <= cx[OUT_W-1:0];
            cursor_y_reg <= cy[OUT_W-1:0];
            btn_reg      <= a_btn_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_x      = cursor_x_reg;
    assign cursor_y      = cursor_y_reg;
    assign left_button   = btn_reg[0];
    assign right_button  = btn_reg[1];
    assign middle_button = btn_reg[2];

endmodule

/* hw/rtl/ps2_mouse_cursor_tracker.sv */
// path: the packet that a third byte completes goes through the packet queue, stage a and the output registers
// throughput: one byte per cycle while in_ready is high; a stalled output backs
// up through a 2-entry packet queue before in_ready drops
// reset (rst_n, async, active low): cursor at 0,0, packet framing restarts at the
// status byte, speed 3, resolution 1024 x 768
module ps2_mouse_cursor_tracker #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2mc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ps2mc_pkg::BYTE_W-1:0]     data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ps2mc_pkg::OUT_W-1:0]      cursor_x,
    output logic [ps2mc_pkg::OUT_W-1:0]      cursor_y,
    output logic                             left_button,
    output logic                             right_button,
    output logic                             middle_button
);
    import ps2mc_pkg::*;

    cfg_t    cfg_reg;
    q_wr_t   q_wr;
    q_rd_t   q_rd;
    logic    pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed         <= SPEED_RST;
            cfg_reg.screen_width  <= WIDTH_RST;
            cfg_reg.screen_height <= HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SPEED:  cfg_reg.speed         <= cfg_data[SPEED_W-1:0];
                CFG_WIDTH:  cfg_reg.screen_width  <= cfg_data[RES_W-1:0];
                CFG_HEIGHT: cfg_reg.screen_height <= cfg_data[RES_W-1:0];
                default:    ;
            endcase
        end
    end

    ps2mc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_rd      (q_rd),
        .q_wr      (q_wr)
    );

    ps2mc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .q_rd  (q_rd)
    );

    ps2mc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_rd          (q_rd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .left_button   (left_button),
        .right_button  (right_button),
        .middle_button (middle_button)
    );

endmodule

/* hw/rtl/ps2mc_checker.sv */
module ps2mc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2mc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [ps2mc_pkg::BYTE_W-1:0]     data_byte,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [ps2mc_pkg::OUT_W-1:0]      cursor_x,
    input  logic [ps2mc_pkg::OUT_W-1:0]      cursor_y,
    input  logic                             left_button,
    input  logic                             right_button,
    input  logic                             middle_button
);
    import ps2mc_pkg::*;

    logic [RES_W-1:0] width_reg;
    logic [RES_W-1:0] height_reg;

    // shadow of the resolution registers, seen from the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_reg <= cfg_data[RES_W-1:0];
            end
            if (cfg_index == CFG_HEIGHT)
            begin
                height_reg <= cfg_data[RES_W-1:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(left_button) && $stable(right_button) && $stable(middle_button))
        else $error("output transaction changed while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

    a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (width_reg != '0) |-> ({1'b0, cursor_x} < width_reg))
        else $error("cursor_x beyond screen width");

    a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (height_reg != '0) |-> ({1'b0, cursor_y} < height_reg))
        else $error("cursor_y beyond screen height");

endmodule

bind ps2_mouse_cursor_tracker ps2mc_checker u_checker (.*);
